// File: src/bvc_pkg.sv
// Shared types, constants and helper functions for the box against voxel map collision block.
package bvc_pkg;

  localparam int unsigned MAX_X_DEF = 64;
  localparam int unsigned MAX_Y_DEF = 64;
  localparam int unsigned MAX_Z_DEF = 64;

  localparam logic [31:0] EMPTY_COLOR = 32'hFFFF_FFFF;
  localparam logic [6:0] SIZE_RESET = 7'd64;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [1:0] REG_SIZE_X = 2'd0;
  localparam logic [1:0] REG_SIZE_Y = 2'd1;
  localparam logic [1:0] REG_SIZE_Z = 2'd2;

  typedef struct packed {
    logic capture;
    logic clr_step;
    logic wr_read;
    logic wr_write;
    logic calc;
    logic mask;
    logic scan_start;
    logic scan_step;
    logic out_load;
    logic out_hit;
  } bvc_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic wr_in_map;
    logic range_ok;
    logic scan_last;
    logic row_hit;
    logic out_busy;
  } bvc_status_t;

  typedef struct packed {
    logic ok;
    logic signed [17:0] fs;
    logic signed [17:0] ls;
  } span_t;

  function automatic int unsigned idx_width(input int unsigned n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

  // Cells that overlap [lo, hi] inside [0, size): from ceil(lo)-1 up to floor(hi).
  function automatic span_t axis_span(input logic signed [23:0] lo,
                                      input logic signed [23:0] hi,
                                      input logic [17:0] size);
    logic signed [25:0] lo_ext;
    logic signed [17:0] ce;
    logic signed [17:0] fl;
    logic signed [17:0] sm1;
    span_t s;
    lo_ext = 26'(lo) + 26'sd255;
    ce = 18'(lo_ext >>> 8);
    fl = 18'(hi >>> 8);
    sm1 = $signed(size) - 18'sd1;
    s.fs = ce - 18'sd1;
    if (s.fs < 18'sd0) begin
      s.fs = 18'sd0;
    end
    s.ls = (fl < sm1) ? fl : sm1;
    s.ok = (s.fs <= s.ls);
    return s;
  endfunction

endpackage

// File: src/bvc_ctrl.sv
// Controller state machine sequencing clearing, voxel writes and box queries.
module bvc_ctrl import bvc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        opcode,
  input  bvc_status_t status,
  output bvc_cmd_t    cmd
);

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_WRD   = 9'b000000100,
    S_WWR   = 9'b000001000,
    S_CALC  = 9'b000010000,
    S_MASK  = 9'b000100000,
    S_SCAN  = 9'b001000000,
    S_DRAIN = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;
  logic   res;
  logic   res_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      res <= 1'b0;
    end else begin
      state <= state_next;
      res <= res_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    res_next = res;
    cmd = '0;
    cmd.out_hit = res;
    case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (status.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next = (opcode == OP_WRITE) ? S_WRD : S_CALC;
        end
      end
      S_WRD: begin
        cmd.wr_read = 1'b1;
        state_next = status.wr_in_map ? S_WWR : S_IDLE;
      end
      S_WWR: begin
        cmd.wr_write = 1'b1;
        state_next = S_IDLE;
      end
      S_CALC: begin
        cmd.calc = 1'b1;
        state_next = S_MASK;
      end
      S_MASK: begin
        cmd.mask = 1'b1;
        if (status.range_ok) begin
          cmd.scan_start = 1'b1;
          state_next = S_SCAN;
        end else begin
          res_next = 1'b0;
          state_next = S_DONE;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.row_hit) begin
          res_next = 1'b1;
          state_next = S_DONE;
        end else if (status.scan_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        res_next = status.row_hit;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!status.out_busy) begin
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule

// File: src/bvc_datapath.sv
// Datapath with the row-organized occupancy memory, scan counters, z mask and output register.
module bvc_datapath import bvc_pkg::*; #(
  parameter int unsigned MAX_X = MAX_X_DEF,
  parameter int unsigned MAX_Y = MAX_Y_DEF,
  parameter int unsigned MAX_Z = MAX_Z_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [5:0]         vox_x,
  input  logic [5:0]         vox_y,
  input  logic [5:0]         vox_z,
  input  logic [31:0]        voxel_color,
  input  logic signed [23:0] box_lo_x,
  input  logic signed [23:0] box_lo_y,
  input  logic signed [23:0] box_lo_z,
  input  logic signed [23:0] box_hi_x,
  input  logic signed [23:0] box_hi_y,
  input  logic signed [23:0] box_hi_z,
  input  logic [6:0]         size_x,
  input  logic [6:0]         size_y,
  input  logic [6:0]         size_z,
  input  bvc_cmd_t           cmd,
  output bvc_status_t        status,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               hit
);

  localparam int unsigned XW = idx_width(MAX_X);
  localparam int unsigned YW = idx_width(MAX_Y);
  localparam int unsigned ZW = idx_width(MAX_Z);
  localparam int unsigned ROWS = MAX_X * MAX_Y;
  localparam int unsigned AW = idx_width(ROWS);

  logic [MAX_Z-1:0] mem [ROWS];
  logic [MAX_Z-1:0] rdata;
  logic [MAX_Z-1:0] wdata;
  logic [AW-1:0]    raddr;
  logic [AW-1:0]    waddr;
  logic             we;

  logic [5:0]         cap_vx;
  logic [5:0]         cap_vy;
  logic [5:0]         cap_vz;
  logic               cap_solid;
  logic signed [23:0] lo_x;
  logic signed [23:0] lo_y;
  logic signed [23:0] lo_z;
  logic signed [23:0] hi_x;
  logic signed [23:0] hi_y;
  logic signed [23:0] hi_z;

  logic [XW-1:0]    fx;
  logic [XW-1:0]    lx;
  logic [YW-1:0]    fy;
  logic [YW-1:0]    ly;
  logic [ZW-1:0]    fz;
  logic [ZW-1:0]    lz;
  logic             range_ok;
  logic [MAX_Z-1:0] zmask;
  logic [XW-1:0]    cx;
  logic [YW-1:0]    cy;
  logic             rd_vld;
  logic [AW-1:0]    clr_cnt;

  logic [17:0]      eff_x;
  logic [17:0]      eff_y;
  logic [17:0]      eff_z;
  span_t            sp_x;
  span_t            sp_y;
  span_t            sp_z;
  logic [AW-1:0]    vox_addr;
  logic [AW-1:0]    scan_addr;
  logic [ZW-1:0]    zshift;

  always_comb begin
    eff_x = (32'(size_x) > MAX_X) ? 18'(MAX_X) : 18'(size_x);
    eff_y = (32'(size_y) > MAX_Y) ? 18'(MAX_Y) : 18'(size_y);
    eff_z = (32'(size_z) > MAX_Z) ? 18'(MAX_Z) : 18'(size_z);
    sp_x = axis_span(lo_x, hi_x, eff_x);
    sp_y = axis_span(lo_y, hi_y, eff_y);
    sp_z = axis_span(lo_z, hi_z, eff_z);
    vox_addr = AW'(AW'(XW'(cap_vx)) * AW'(MAX_Y) + AW'(YW'(cap_vy)));
    scan_addr = AW'(AW'(cx) * AW'(MAX_Y) + AW'(cy));
    zshift = ZW'(MAX_Z - 1) - lz;
    raddr = cmd.wr_read ? vox_addr : scan_addr;
    wdata = rdata;
    wdata[ZW'(cap_vz)] = cap_solid;
    we = cmd.clr_step | cmd.wr_write;
    waddr = cmd.clr_step ? clr_cnt : vox_addr;
    if (cmd.clr_step) begin
      wdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cap_vx <= vox_x;
      cap_vy <= vox_y;
      cap_vz <= vox_z;
      cap_solid <= (voxel_color != EMPTY_COLOR);
      lo_x <= box_lo_x;
      lo_y <= box_lo_y;
      lo_z <= box_lo_z;
      hi_x <= box_hi_x;
      hi_y <= box_hi_y;
      hi_z <= box_hi_z;
    end
    if (cmd.calc) begin
      fx <= XW'(sp_x.fs);
      lx <= XW'(sp_x.ls);
      fy <= YW'(sp_y.fs);
      ly <= YW'(sp_y.ls);
      fz <= ZW'(sp_z.fs);
      lz <= ZW'(sp_z.ls);
      range_ok <= sp_x.ok & sp_y.ok & sp_z.ok;
    end
    if (cmd.mask) begin
      zmask <= ({MAX_Z{1'b1}} << fz) & ({MAX_Z{1'b1}} >> zshift);
    end
    if (cmd.scan_start) begin
      cx <= fx;
      cy <= fy;
    end else if (cmd.scan_step) begin
      if (cy == ly) begin
        cy <= fy;
        cx <= cx + XW'(1);
      end else begin
        cy <= cy + YW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
      clr_cnt <= '0;
      out_valid <= 1'b0;
      hit <= 1'b0;
    end else begin
      rd_vld <= cmd.scan_step;
      if (cmd.clr_step) begin
        clr_cnt <= clr_cnt + AW'(1);
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
        hit <= cmd.out_hit;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    status.clr_last = (clr_cnt == AW'(ROWS - 1));
    status.wr_in_map = (32'(cap_vx) < MAX_X) && (32'(cap_vy) < MAX_Y) &&
                       (32'(cap_vz) < MAX_Z);
    status.range_ok = range_ok;
    status.scan_last = (cx == lx) && (cy == ly);
    status.row_hit = rd_vld & (|(rdata & zmask));
    status.out_busy = out_valid & ~out_ready;
  end

endmodule

// File: src/box_voxel_collision.sv
// Top level: a voxel write reads the z row of its voxel and, if the voxel lies inside the map,
// writes it back changed before the next word is accepted. A query sets up its cell ranges
// (S_CALC) and z mask (S_MASK), then reads one (x, y) row per cycle, since the map returns a
// full z row per read, then posts its result. A hit ends the scan early; the worst case is MAX_X*MAX_Y rows.
// A result still waiting at the output holds the query in its last cycle until it is taken.
// After reset the map is cleared one row per cycle, all MAX_X*MAX_Y rows (4096 by default).
module box_voxel_collision import bvc_pkg::*; #(
  parameter int unsigned MAX_X = MAX_X_DEF,
  parameter int unsigned MAX_Y = MAX_Y_DEF,
  parameter int unsigned MAX_Z = MAX_Z_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               opcode,
  input  logic [5:0]         vox_x,
  input  logic [5:0]         vox_y,
  input  logic [5:0]         vox_z,
  input  logic [31:0]        voxel_color,
  input  logic signed [23:0] box_lo_x,
  input  logic signed [23:0] box_lo_y,
  input  logic signed [23:0] box_lo_z,
  input  logic signed [23:0] box_hi_x,
  input  logic signed [23:0] box_hi_y,
  input  logic signed [23:0] box_hi_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               hit
);

  logic [6:0]  size_x;
  logic [6:0]  size_y;
  logic [6:0]  size_z;
  logic        cfg_we;
  bvc_cmd_t    cmd;
  bvc_status_t status;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_x <= SIZE_RESET;
      size_y <= SIZE_RESET;
      size_z <= SIZE_RESET;
    end else if (cfg_we) begin
      case (paddr[3:2])
        REG_SIZE_X: size_x <= pwdata[6:0];
        REG_SIZE_Y: size_y <= pwdata[6:0];
        REG_SIZE_Z: size_z <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_SIZE_X: prdata = 32'(size_x);
      REG_SIZE_Y: prdata = 32'(size_y);
      REG_SIZE_Z: prdata = 32'(size_z);
      default:    prdata = '0;
    endcase
  end

  bvc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .opcode   (opcode),
    .status   (status),
    .cmd      (cmd)
  );

  bvc_datapath #(
    .MAX_X (MAX_X),
    .MAX_Y (MAX_Y),
    .MAX_Z (MAX_Z)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .vox_x       (vox_x),
    .vox_y       (vox_y),
    .vox_z       (vox_z),
    .voxel_color (voxel_color),
    .box_lo_x    (box_lo_x),
    .box_lo_y    (box_lo_y),
    .box_lo_z    (box_lo_z),
    .box_hi_x    (box_hi_x),
    .box_hi_y    (box_hi_y),
    .box_hi_z    (box_hi_z),
    .size_x      (size_x),
    .size_y      (size_y),
    .size_z      (size_z),
    .cmd         (cmd),
    .status      (status),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .hit         (hit)
  );

endmodule

// File: verif/tb_top.sv
// Self-checking testbench for box_voxel_collision: drives voxel writes and box queries, predicts every hit flag and checks it.
module tb_top;
  import bvc_pkg::*;

  localparam int Q_ONE = 256;
  localparam int Q_MIN = -8388608;
  localparam int Q_MAX = 8388607;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_LIMIT = 50000;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic opcode;
    logic [5:0] vx;
    logic [5:0] vy;
    logic [5:0] vz;
    logic [31:0] color;
    logic [2:0][23:0] lo;
    logic [2:0][23:0] hi;
  } voxel_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic opcode = OP_WRITE;
  logic [5:0] vox_x = '0;
  logic [5:0] vox_y = '0;
  logic [5:0] vox_z = '0;
  logic [31:0] voxel_color = '0;
  logic signed [23:0] box_lo_x = '0;
  logic signed [23:0] box_lo_y = '0;
  logic signed [23:0] box_lo_z = '0;
  logic signed [23:0] box_hi_x = '0;
  logic signed [23:0] box_hi_y = '0;
  logic signed [23:0] box_hi_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic hit;

  logic [MAX_Z_DEF-1:0] occ_rows [0:MAX_X_DEF-1][0:MAX_Y_DEF-1];
  logic [6:0] size_cfg [3];
  logic hit_expected_q [$];
  logic expected_hit;
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_request = 1'b0;
  int hold_left = 0;

  box_voxel_collision dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .opcode(opcode),
    .vox_x(vox_x),
    .vox_y(vox_y),
    .vox_z(vox_z),
    .voxel_color(voxel_color),
    .box_lo_x(box_lo_x),
    .box_lo_y(box_lo_y),
    .box_lo_z(box_lo_z),
    .box_hi_x(box_hi_x),
    .box_hi_y(box_hi_y),
    .box_hi_z(box_hi_z),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .hit(hit)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic void note_failure(input string msg);
    errors++;
    if (errors <= 10) begin
      $display("%s", msg);
    end
  endfunction

  function automatic int axis_extent(input int a);
    int cap;
    cap = (a == 0) ? MAX_X_DEF : (a == 1) ? MAX_Y_DEF : MAX_Z_DEF;
    return (int'(size_cfg[a]) > cap) ? cap : int'(size_cfg[a]);
  endfunction

  function automatic bit overlap_cells(input logic signed [23:0] lo, input logic signed [23:0] hi,
                                       input int extent, output int first, output int last);
    int lo_i;
    int hi_i;
    int a;
    int b;
    lo_i = lo;
    hi_i = hi;
    a = (lo_i >>> 8) - 1;
    b = -((-hi_i) >>> 8) + 1;
    a = (a < 0) ? 0 : (a > extent) ? extent : a;
    b = (b < 0) ? 0 : (b > extent) ? extent : b;
    first = -1;
    last = -1;
    for (int c = a; c < b; c++) begin
      if (c * Q_ONE <= hi_i && lo_i <= (c + 1) * Q_ONE) begin
        if (first < 0) begin
          first = c;
        end
        last = c;
      end
    end
    return first >= 0;
  endfunction

  function automatic logic box_hits_map(input voxel_word_t w);
    int f [3];
    int l [3];
    bit found;
    logic [MAX_Z_DEF-1:0] zmask;
    for (int a = 0; a < 3; a++) begin
      found = overlap_cells($signed(w.lo[a]), $signed(w.hi[a]), axis_extent(a), f[a], l[a]);
      if (!found) begin
        return 1'b0;
      end
    end
    zmask = '0;
    for (int z = f[2]; z <= l[2]; z++) begin
      zmask[z] = 1'b1;
    end
    for (int x = f[0]; x <= l[0]; x++) begin
      for (int y = f[1]; y <= l[1]; y++) begin
        if ((occ_rows[x][y] & zmask) != '0) begin
          return 1'b1;
        end
      end
    end
    return 1'b0;
  endfunction

  function automatic voxel_word_t random_word();
    voxel_word_t w;
    w.opcode = 1'($urandom_range(1));
    w.vx = 6'($urandom);
    w.vy = 6'($urandom);
    w.vz = 6'($urandom);
    w.color = $urandom;
    for (int a = 0; a < 3; a++) begin
      w.lo[a] = 24'($urandom);
      w.hi[a] = 24'($urandom);
    end
    return w;
  endfunction

  function automatic voxel_word_t random_voxel_write();
    voxel_word_t w;
    w = random_word();
    w.opcode = OP_WRITE;
    if ($urandom_range(3) != 0) begin
      w.vx = 6'($urandom_range(15));
      w.vy = 6'($urandom_range(15));
      w.vz = 6'($urandom_range(15));
    end
    if ($urandom_range(3) == 0) begin
      w.color = EMPTY_COLOR;
    end
    return w;
  endfunction

  function automatic voxel_word_t random_box_query();
    voxel_word_t w;
    int r;
    int lo_i;
    int hi_i;
    int span;
    w = random_word();
    w.opcode = OP_QUERY;
    r = $urandom_range(99);
    if (r >= 3 && r < 7) begin
      return w;
    end
    for (int a = 0; a < 3; a++) begin
      if (r < 3) begin
        lo_i = -int'($urandom_range(8388608));
        hi_i = int'($urandom_range(Q_MAX, 64 * Q_ONE));
      end else begin
        lo_i = int'($urandom_range(22 * Q_ONE)) - 4 * Q_ONE;
        if (r < 12) begin
          span = -int'($urandom_range(2 * Q_ONE, 1));
        end else begin
          span = int'($urandom_range(3 * Q_ONE));
        end
        if ($urandom_range(2) == 0) begin
          lo_i = lo_i & ~(Q_ONE - 1);
          span = span & ~(Q_ONE - 1);
        end
        hi_i = lo_i + span;
      end
      w.lo[a] = lo_i[23:0];
      w.hi[a] = hi_i[23:0];
    end
    return w;
  endfunction

  // Called at a rising edge; returns at the edge where the word is taken, with valid still high.
  task automatic send_word(input voxel_word_t w);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= w.opcode;
    vox_x <= w.vx;
    vox_y <= w.vy;
    vox_z <= w.vz;
    voxel_color <= w.color;
    box_lo_x <= w.lo[0];
    box_lo_y <= w.lo[1];
    box_lo_z <= w.lo[2];
    box_hi_x <= w.hi[0];
    box_hi_y <= w.hi[1];
    box_hi_z <= w.hi[2];
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    if (w.opcode == OP_QUERY) begin
      hit_expected_q.push_back(box_hits_map(w));
    end else begin
      occ_rows[w.vx][w.vy][w.vz] = (w.color != EMPTY_COLOR);
    end
  endtask

  task automatic wait_drained();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    @(posedge clk);
    while (hit_expected_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (hit_expected_q.size() != 0) begin
      note_failure($sformatf("%0d expected results never arrived", hit_expected_q.size()));
      hit_expected_q.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_size_reg(input logic [1:0] idx, input logic [6:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {25'($urandom), val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) begin
      @(posedge clk);
    end
    size_cfg[idx] = val;
  endtask

  task automatic set_sizes(input logic [6:0] sx, input logic [6:0] sy, input logic [6:0] sz);
    wait_drained();
    write_size_reg(REG_SIZE_X, sx);
    write_size_reg(REG_SIZE_Y, sy);
    write_size_reg(REG_SIZE_Z, sz);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_at(input int x, input int y, input int z, input logic [31:0] color);
    voxel_word_t w;
    w = random_word();
    w.opcode = OP_WRITE;
    w.vx = x[5:0];
    w.vy = y[5:0];
    w.vz = z[5:0];
    w.color = color;
    send_word(w);
  endtask

  task automatic query_at(input int lx, input int ly, input int lz,
                          input int hx, input int hy, input int hz);
    voxel_word_t w;
    w = random_word();
    w.opcode = OP_QUERY;
    w.lo[0] = lx[23:0];
    w.lo[1] = ly[23:0];
    w.lo[2] = lz[23:0];
    w.hi[0] = hx[23:0];
    w.hi[1] = hy[23:0];
    w.hi[2] = hz[23:0];
    send_word(w);
  endtask

  task automatic query_cell(input int x, input int y, input int z);
    query_at(x * Q_ONE + Q_ONE / 4, y * Q_ONE + Q_ONE / 4, z * Q_ONE + Q_ONE / 4,
             x * Q_ONE + 3 * Q_ONE / 4, y * Q_ONE + 3 * Q_ONE / 4, z * Q_ONE + 3 * Q_ONE / 4);
  endtask

  task automatic run_reset();
    for (int x = 0; x < MAX_X_DEF; x++) begin
      for (int y = 0; y < MAX_Y_DEF; y++) begin
        occ_rows[x][y] = '0;
      end
    end
    for (int a = 0; a < 3; a++) begin
      size_cfg[a] = SIZE_RESET;
    end
    send_idle_pct = 12;
    recv_idle_pct = 60;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
  endtask

  task automatic test_directed_cases();
    write_at(0, 0, 0, 32'h0000_0000);
    write_at(63, 63, 63, 32'hFFFF_FFFE);
    write_at(5, 5, 5, 32'h1234_5678);
    write_at(5, 6, 5, EMPTY_COLOR);
    write_at(42, 21, 63, 32'h0000_0001);
    query_cell(0, 0, 0);
    query_at(6 * Q_ONE, 5 * Q_ONE, 5 * Q_ONE, 7 * Q_ONE, 5 * Q_ONE + 128, 5 * Q_ONE + 128);
    query_at(6 * Q_ONE + 1, 5 * Q_ONE, 5 * Q_ONE, 7 * Q_ONE, 5 * Q_ONE + 128, 5 * Q_ONE + 128);
    query_at(4 * Q_ONE, 5 * Q_ONE, 5 * Q_ONE, 5 * Q_ONE, 5 * Q_ONE + 128, 5 * Q_ONE + 128);
    query_at(4 * Q_ONE, 5 * Q_ONE, 5 * Q_ONE, 5 * Q_ONE - 1, 5 * Q_ONE + 128, 5 * Q_ONE + 128);
    query_at(5 * Q_ONE + 192, 5 * Q_ONE + 64, 5 * Q_ONE + 64,
             5 * Q_ONE + 64, 5 * Q_ONE + 192, 5 * Q_ONE + 192);
    query_at(9 * Q_ONE, 5 * Q_ONE, 5 * Q_ONE, 2 * Q_ONE, 6 * Q_ONE, 6 * Q_ONE);
    query_at(63 * Q_ONE + 128, 63 * Q_ONE + 128, 63 * Q_ONE + 128, Q_MAX, Q_MAX, Q_MAX);
    query_at(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX);
    query_at(-10 * Q_ONE, -10 * Q_ONE, -10 * Q_ONE, -2 * Q_ONE, -2 * Q_ONE, -2 * Q_ONE);
    write_at(0, 0, 0, EMPTY_COLOR);
    write_at(63, 63, 63, EMPTY_COLOR);
    write_at(5, 5, 5, EMPTY_COLOR);
    write_at(42, 21, 63, EMPTY_COLOR);
    query_at(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX);
    query_at(Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN);
  endtask

  task automatic probe_map_corners();
    query_at(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX);
    query_cell(63, 63, 63);
    query_cell(7, 3, 9);
    query_cell(0, 0, 0);
  endtask

  task automatic test_size_registers();
    write_at(0, 0, 0, 32'h00FF_00FF);
    write_at(7, 3, 9, 32'h8000_0000);
    write_at(63, 63, 63, 32'h7FFF_FFFF);
    set_sizes(7'd0, 7'd64, 7'd64);
    probe_map_corners();
    set_sizes(7'd64, 7'd0, 7'd64);
    probe_map_corners();
    set_sizes(7'd64, 7'd64, 7'd0);
    probe_map_corners();
    set_sizes(7'd1, 7'd1, 7'd1);
    probe_map_corners();
    set_sizes(7'd127, 7'd127, 7'd127);
    probe_map_corners();
    set_sizes(7'd8, 7'd4, 7'd10);
    probe_map_corners();
    set_sizes(7'd64, 7'd64, 7'd64);
    probe_map_corners();
  endtask

  task automatic test_random_traffic(input int count, input int send_pct, input int recv_pct,
                                     input logic [6:0] sx, input logic [6:0] sy,
                                     input logic [6:0] sz);
    set_sizes(sx, sy, sz);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 45) begin
        send_word(random_voxel_write());
      end else begin
        send_word(random_box_query());
      end
    end
  endtask

  task automatic test_output_backpressure();
    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request = 1'b1;
    for (int i = 0; i < 40; i++) begin
      if (i % 4 == 0) begin
        send_word(random_voxel_write());
      end else begin
        query_cell($urandom_range(15), $urandom_range(15), $urandom_range(15));
      end
    end
    wait_drained();
    for (int i = 0; i < 20; i++) begin
      send_word(random_box_query());
    end
  endtask

  always @(posedge clk) begin
    if (hold_request) begin
      hold_left = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !rst && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (hit_expected_q.size() == 0) begin
        note_failure($sformatf("unexpected result word: hit %0b", hit));
      end else begin
        expected_hit = hit_expected_q.pop_front();
        if (hit !== expected_hit) begin
          note_failure($sformatf("hit mismatch: expected %0b, actual %0b", expected_hit, hit));
        end
      end
    end
  end

  initial begin
    run_reset();
    test_directed_cases();
    test_size_registers();
    test_random_traffic(330, 12, 60, 7'd64, 7'd64, 7'd64);
    test_random_traffic(330, 60, 12, 7'd17, 7'd127, 7'd40);
    test_random_traffic(330, 0, 0, 7'd64, 7'd64, 7'd64);
    test_output_backpressure();
    wait_drained();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  initial begin
    #30000000;
    $display("tb_top failed");
    $finish;
  end

endmodule
